@@ rtl/core/olie_pkg.sv @@
// Package for the ordered list insert engine.
// Holds field widths, operation codes, the default capacity and the result struct.
// No dependencies.
`default_nettype none

package olie_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned POS_W   = 7;
  localparam int unsigned WORD_W  = 32;
  localparam int unsigned COUNT_W = 7;

  // Operation codes carried in the kind field
  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_GET    = 2'd2,
    KIND_LOCATE = 2'd3
  } kind_t;

  // One result beat
  typedef struct packed {
    logic                      ok;
    logic signed [WORD_W-1:0]  read_value;
    logic [POS_W-1:0]          found_position;
    logic [COUNT_W-1:0]        count;
    logic                      empty_res;
  } olie_res_t;

endpackage : olie_pkg

`default_nettype wire

@@ rtl/core/olie_if.sv @@
// Valid/ready channel interfaces for the ordered list insert engine.
// Depends on olie_pkg for field widths.
`default_nettype none

interface olie_in_if;
  logic                                 valid;
  logic                                 ready;
  logic [olie_pkg::KIND_W-1:0]          kind;
  logic [olie_pkg::POS_W-1:0]           position;
  logic signed [olie_pkg::WORD_W-1:0]   value;

  modport source (output valid, kind, position, value, input ready);
  modport sink   (input valid, kind, position, value, output ready);
endinterface : olie_in_if

interface olie_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 ok;
  logic signed [olie_pkg::WORD_W-1:0]   read_value;
  logic [olie_pkg::POS_W-1:0]           found_position;
  logic [olie_pkg::COUNT_W-1:0]         count;
  logic                                 empty_res;

  modport source (output valid, ok, read_value, found_position, count, empty_res,
                  input ready);
  modport sink   (input valid, ok, read_value, found_position, count, empty_res,
                  output ready);
endinterface : olie_out_if

`default_nettype wire

@@ rtl/core/olie_out_stage.sv @@
// Output holding register for the ordered list insert engine.
// Depends on olie_pkg (result struct) and olie_out_if.
`default_nettype none

module olie_out_stage (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               load,
  input  wire olie_pkg::olie_res_t res,
  output logic                    free,
  olie_out_if.source              out_ch
);
  import olie_pkg::*;

  logic      valid_r;
  olie_res_t res_r;

  // Register can take a new beat when empty or being drained this cycle
  assign free = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_ch.valid          = valid_r;
  assign out_ch.ok             = res_r.ok;
  assign out_ch.read_value     = res_r.read_value;
  assign out_ch.found_position = res_r.found_position;
  assign out_ch.count          = res_r.count;
  assign out_ch.empty_res      = res_r.empty_res;

endmodule : olie_out_stage

`default_nettype wire

@@ rtl/core/ordered_list_insert_engine.sv @@
// Top level of the ordered list insert engine: sequencer, entry memory, length.
// Depends on olie_pkg, olie_in_if, olie_out_if and olie_out_stage.
`default_nettype none

// A bounded list of signed 32-bit words kept in a single-port-write,
// single-port-read memory of CAPACITY entries. One operation per input beat;
// the engine is busy (in_ch.ready low) until that operation has finished.
// An insert at the tail writes the word without shifting; a failed insert goes
// straight to the result. Insert and locate walk the memory one entry per cycle
// through its one read port and one write port, so their time grows with the
// list length. A finished result waits in an output register, so the next
// operation can be accepted while the previous result is still held.
// There is no clearing pass; clear only resets the length.
module ordered_list_insert_engine #(
  parameter int unsigned CAPACITY = olie_pkg::CAPACITY_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  olie_in_if.sink    in_ch,
  olie_out_if.source out_ch
);
  import olie_pkg::*;

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned LW = $clog2(CAPACITY + 1);
  localparam int unsigned CW = ((LW > POS_W) ? LW : POS_W) + 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SHIFT,
    S_SHIFT_LAST,
    S_INS_WR,
    S_GET_RD,
    S_GET_DATA,
    S_LOC,
    S_EMIT
  } state_t;

  state_t                    state_r, state_nxt;
  logic [LW-1:0]             len_r, len_nxt;
  logic [KIND_W-1:0]         kind_r;
  logic [POS_W-1:0]          pos_r;
  logic [WORD_W-1:0]         word_r;
  logic [AW-1:0]             src_r, src_nxt;
  logic [AW-1:0]             wr_addr_r, wr_addr_nxt;
  logic                      pend_r, pend_nxt;
  logic [LW-1:0]             idx_r, idx_nxt;
  logic [AW-1:0]             cmp_idx_r, cmp_idx_nxt;
  logic                      ok_r, ok_nxt;
  logic [WORD_W-1:0]         rd_r, rd_nxt;
  logic [POS_W-1:0]          fp_r, fp_nxt;

  logic [WORD_W-1:0]         mem [CAPACITY];
  logic [WORD_W-1:0]         rd_data_r;
  logic [AW-1:0]             rd_addr;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [WORD_W-1:0]         mem_wdata;

  logic [CW-1:0]             pos_ext, len_ext, pm1_ext, fp_ext;
  logic                      ins_ok, get_ok, ins_tail;
  logic                      res_load, out_free;
  olie_res_t                 res;

  // Position checks against the current length, in a common width
  always_comb begin
    pos_ext  = CW'(pos_r);
    len_ext  = CW'(len_r);
    pm1_ext  = pos_ext - CW'(1);
    fp_ext   = CW'(cmp_idx_r) + CW'(1);
    ins_ok   = (pos_ext != '0) && (pos_ext <= len_ext + CW'(1))
               && (len_ext < CW'(CAPACITY));
    get_ok   = (pos_ext != '0) && (pos_ext <= len_ext);
    ins_tail = (pos_ext == len_ext + CW'(1));
  end

  // Sequencer next-state and memory port control
  always_comb begin
    state_nxt   = state_r;
    len_nxt     = len_r;
    src_nxt     = src_r;
    wr_addr_nxt = wr_addr_r;
    pend_nxt    = pend_r;
    idx_nxt     = idx_r;
    cmp_idx_nxt = cmp_idx_r;
    ok_nxt      = ok_r;
    rd_nxt      = rd_r;
    fp_nxt      = fp_r;
    rd_addr     = '0;
    mem_we      = 1'b0;
    mem_waddr   = wr_addr_r;
    mem_wdata   = rd_data_r;
    res_load    = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          state_nxt = S_DECODE;
        end
      end

      S_DECODE: begin
        ok_nxt   = 1'b1;
        rd_nxt   = '0;
        fp_nxt   = '0;
        pend_nxt = 1'b0;
        idx_nxt  = '0;
        unique case (kind_r)
          KIND_CLEAR: begin
            len_nxt   = '0;
            state_nxt = S_EMIT;
          end
          KIND_INSERT: begin
            if (!ins_ok) begin
              ok_nxt    = 1'b0;
              state_nxt = S_EMIT;
            end else if (ins_tail) begin
              state_nxt = S_INS_WR;
            end else begin
              src_nxt   = AW'(len_ext - CW'(1));
              state_nxt = S_SHIFT;
            end
          end
          KIND_GET: begin
            if (get_ok) begin
              state_nxt = S_GET_RD;
            end else begin
              ok_nxt    = 1'b0;
              state_nxt = S_EMIT;
            end
          end
          default: begin
            state_nxt = S_LOC;
          end
        endcase
      end

      // Read entry src, write the entry read last cycle one place up
      S_SHIFT: begin
        rd_addr     = src_r;
        mem_we      = pend_r;
        wr_addr_nxt = src_r + AW'(1);
        pend_nxt    = 1'b1;
        if (src_r == AW'(pm1_ext)) begin
          state_nxt = S_SHIFT_LAST;
        end else begin
          src_nxt = src_r - AW'(1);
        end
      end

      S_SHIFT_LAST: begin
        mem_we    = 1'b1;
        state_nxt = S_INS_WR;
      end

      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(pm1_ext);
        mem_wdata = word_r;
        len_nxt   = len_r + LW'(1);
        state_nxt = S_EMIT;
      end

      S_GET_RD: begin
        rd_addr   = AW'(pm1_ext);
        state_nxt = S_GET_DATA;
      end

      S_GET_DATA: begin
        rd_nxt    = rd_data_r;
        state_nxt = S_EMIT;
      end

      // Scan reads one entry a cycle and compares the one read before
      S_LOC: begin
        if (pend_r && (rd_data_r == word_r)) begin
          fp_nxt    = fp_ext[POS_W-1:0];
          state_nxt = S_EMIT;
        end else if (idx_r < len_r) begin
          rd_addr     = idx_r[AW-1:0];
          pend_nxt    = 1'b1;
          cmp_idx_nxt = idx_r[AW-1:0];
          idx_nxt     = idx_r + LW'(1);
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          state_nxt = S_EMIT;
        end
      end

      S_EMIT: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE);

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      len_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      pend_r  <= pend_nxt;
    end
  end

  // Working registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      kind_r <= in_ch.kind;
      pos_r  <= in_ch.position;
      word_r <= in_ch.value;
    end
    src_r     <= src_nxt;
    wr_addr_r <= wr_addr_nxt;
    idx_r     <= idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    ok_r      <= ok_nxt;
    rd_r      <= rd_nxt;
    fp_r      <= fp_nxt;
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Result assembly
  always_comb begin
    res.ok             = ok_r;
    res.read_value     = rd_r;
    res.found_position = fp_r;
    res.count          = len_ext[COUNT_W-1:0];
    res.empty_res      = (len_r == '0);
  end

  olie_out_stage u_out_stage (
    .clk    (clk),
    .rst_n  (rst_n),
    .load   (res_load),
    .res    (res),
    .free   (out_free),
    .out_ch (out_ch)
  );

endmodule : ordered_list_insert_engine

`default_nettype wire

@@ bench/tb_ordered_list_insert_engine.sv @@
// Self-checking bench for ordered_list_insert_engine: a shadow list predicts every result
// beat, and randomized valid/ready traffic drives both channels of the block.
// Depends on olie_pkg, olie_in_if and olie_out_if from the RTL.
`default_nettype none

module tb_ordered_list_insert_engine;
  timeunit 1ns;
  timeprecision 1ps;

  import olie_pkg::*;

  localparam int unsigned LIST_CAP   = CAPACITY_DEF;
  localparam int unsigned OP_TARGET  = 450;
  localparam int unsigned STALL_LEN  = 300;
  localparam int unsigned DRAIN_WAIT = 100;
  localparam int unsigned WDOG_LIMIT = 4000;

  // Shadow copy of the list: predicts each result and checks the beats in order
  class list_shadow;
    logic signed [WORD_W-1:0] words [LIST_CAP];
    int unsigned              list_len;
    olie_res_t                pending_replies [$];
    int unsigned              mismatch_count;

    function new();
      list_len       = 0;
      mismatch_count = 0;
      foreach (words[i]) words[i] = '0;
    endfunction

    // Apply one accepted operation and queue the result it must produce
    function void note_op(kind_t op, logic [POS_W-1:0] pos, logic signed [WORD_W-1:0] word);
      olie_res_t r;
      int        j;
      r = '0;
      case (op)
        KIND_CLEAR: begin
          list_len = 0;
          r.ok     = 1'b1;
        end
        KIND_INSERT: begin
          if (pos >= 1 && pos <= list_len + 1 && list_len < LIST_CAP) begin
            for (j = list_len; j >= pos; j--) words[j] = words[j-1];
            words[pos-1] = word;
            list_len++;
            r.ok = 1'b1;
          end
        end
        KIND_GET: begin
          if (pos >= 1 && pos <= list_len) begin
            r.read_value = words[pos-1];
            r.ok         = 1'b1;
          end
        end
        default: begin
          // locate: first match wins, 0 when absent
          r.ok = 1'b1;
          for (j = 0; j < list_len; j++) begin
            if (words[j] == word) begin
              r.found_position = POS_W'(j + 1);
              break;
            end
          end
        end
      endcase
      r.count     = COUNT_W'(list_len);
      r.empty_res = (list_len == 0);
      pending_replies.push_back(r);
    endfunction

    function void report(string field, longint want, longint got);
      mismatch_count++;
      $display("%0t ns: %s mismatch, expected %0d (0x%0h), got %0d (0x%0h)",
               $time, field, want, want, got, got);
    endfunction

    // Compare one result beat with the oldest prediction
    function void check_reply(olie_res_t got);
      olie_res_t want;
      if (pending_replies.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: result beat with no prediction pending, got 0x%0h", $time, got);
        return;
      end
      want = pending_replies.pop_front();
      if (got.ok !== want.ok)                 report("ok", want.ok, got.ok);
      if (got.read_value !== want.read_value) report("read_value", want.read_value,
                                                     got.read_value);
      if (got.found_position !== want.found_position)
        report("found_position", want.found_position, got.found_position);
      if (got.count !== want.count)           report("count", want.count, got.count);
      if (got.empty_res !== want.empty_res)   report("empty_res", want.empty_res,
                                                     got.empty_res);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;

  olie_in_if  in_bus ();
  olie_out_if out_bus ();

  ordered_list_insert_engine uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  list_shadow  shadow = new();
  int unsigned ops_sent;
  bit          steady;         // no idling on either side while set
  bit          stall_request;  // asks the receiver for one long hold-off
  int unsigned idle_cycles;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    rst_n          = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.kind    = KIND_CLEAR;
    in_bus.position = '0;
    in_bus.value   = '0;
    out_bus.ready  = 1'b0;
    ops_sent       = 0;
    steady         = 1'b0;
    stall_request  = 1'b0;
    idle_cycles    = 0;
  end

  // Offer one operation, with random idle cycles in front, until the block takes it
  task automatic send_op(input kind_t op, input logic [POS_W-1:0] pos,
                         input logic signed [WORD_W-1:0] word);
    while (!steady && $urandom_range(0, 99) < 21) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid    <= 1'b1;
    in_bus.kind     <= op;
    in_bus.position <= pos;
    in_bus.value    <= word;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    shadow.note_op(op, pos, word);
    ops_sent++;
    steady = (ops_sent >= 150 && ops_sent < 230);
  endtask

  // Stop offering and wait until every predicted beat has come back
  task automatic wait_for_replies();
    in_bus.valid <= 1'b0;
    while (shadow.pending_replies.size() != 0) @(posedge clk);
  endtask

  // Mostly random words, with a small pool so duplicates and matches are common
  function automatic logic signed [WORD_W-1:0] pick_word();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4)  return $signed(WORD_W'($urandom_range(0, 7))) - 4;
    if (sel == 4) return {1'b1, {(WORD_W-1){1'b0}}};
    if (sel == 5) return {1'b0, {(WORD_W-1){1'b1}}};
    return $urandom;
  endfunction

  // Result channel: check each beat, then choose ready for the next edge
  initial begin
    int unsigned hold_left;
    olie_res_t   seen;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_bus.valid && out_bus.ready) begin
        seen.ok             = out_bus.ok;
        seen.read_value     = out_bus.read_value;
        seen.found_position = out_bus.found_position;
        seen.count          = out_bus.count;
        seen.empty_res      = out_bus.empty_res;
        shadow.check_reply(seen);
      end
      if (stall_request) begin
        stall_request = 1'b0;
        hold_left     = STALL_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= steady || ($urandom_range(0, 99) >= 21);
      end
    end
  end

  // Watchdog: too long with no beat on either channel ends the run
  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Stimulus
  initial begin
    int unsigned episode;
    int unsigned fill_goal;
    int unsigned steps;
    int unsigned pick;
    int unsigned len;
    bit          hold_done;
    bit          drain_done;
    episode    = 0;
    hold_done  = 1'b0;
    drain_done = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty list, bad positions, extremes, duplicates, clear
    send_op(KIND_GET,    7'd1,   32'sd0);
    send_op(KIND_GET,    7'd0,   32'sd0);
    send_op(KIND_LOCATE, 7'd0,   32'sd0);
    send_op(KIND_INSERT, 7'd0,   32'sd11);
    send_op(KIND_INSERT, 7'd2,   32'sd12);
    send_op(KIND_INSERT, 7'd1,   32'sh8000_0000);
    send_op(KIND_INSERT, 7'd1,   32'sh7FFF_FFFF);
    send_op(KIND_INSERT, 7'd3,   -32'sd1);
    send_op(KIND_INSERT, 7'd2,   32'sd0);
    send_op(KIND_INSERT, 7'd6,   32'sd5);
    send_op(KIND_INSERT, 7'd127, 32'sd6);
    send_op(KIND_GET,    7'd1,   32'sd0);
    send_op(KIND_GET,    7'd4,   32'sd0);
    send_op(KIND_GET,    7'd5,   32'sd0);
    send_op(KIND_GET,    7'd127, -32'sd1);
    send_op(KIND_LOCATE, 7'd127, -32'sd1);
    send_op(KIND_LOCATE, 7'd0,   32'sh1234_5678);
    send_op(KIND_INSERT, 7'd2,   -32'sd1);
    send_op(KIND_LOCATE, 7'd0,   -32'sd1);
    send_op(KIND_LOCATE, 7'd0,   32'sh8000_0000);
    send_op(KIND_CLEAR,  7'd127, -32'sd1);
    send_op(KIND_GET,    7'd1,   32'sd0);
    send_op(KIND_LOCATE, 7'd0,   -32'sd1);
    send_op(KIND_INSERT, 7'd1,   32'sh5555_AAAA);
    send_op(KIND_INSERT, 7'd64,  32'sd7);

    // Random episodes: clear, then grow toward a goal; every sixth one fills the store
    while (ops_sent < OP_TARGET) begin
      episode++;
      fill_goal = (episode % 6 == 1) ? LIST_CAP : $urandom_range(1, 24);
      steps     = (fill_goal == LIST_CAP) ? 200 : $urandom_range(20, 60);
      send_op(KIND_CLEAR, POS_W'($urandom_range(0, 127)), $urandom);
      for (int unsigned s = 0; s < steps && ops_sent < OP_TARGET; s++) begin
        if (!hold_done && ops_sent >= 100) begin
          hold_done     = 1'b1;
          stall_request = 1'b1;
        end
        if (!drain_done && ops_sent >= 250) begin
          drain_done = 1'b1;
          wait_for_replies();
        end
        pick = $urandom_range(0, 99);
        len  = shadow.list_len;
        if (pick < 45 && (len < fill_goal || len == LIST_CAP)) begin
          // at full length this is the full-store failure
          send_op(KIND_INSERT, POS_W'($urandom_range(1, len + 1)), pick_word());
        end else if (pick < 65 && len > 0) begin
          send_op(KIND_GET, POS_W'($urandom_range(1, len)), $urandom);
        end else if (pick < 75 && len > 0) begin
          send_op(KIND_LOCATE, POS_W'($urandom_range(0, 127)),
                  shadow.words[$urandom_range(0, len - 1)]);
        end else if (pick < 85) begin
          send_op(KIND_LOCATE, POS_W'($urandom_range(0, 127)), pick_word());
        end else begin
          // noise: any kind, any position, any word
          send_op(kind_t'($urandom_range(0, 3)), POS_W'($urandom_range(0, 127)),
                  $urandom);
        end
      end
    end

    wait_for_replies();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (shadow.mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule : tb_ordered_list_insert_engine

`default_nettype wire
